[rtl/core/stepper_half_step_driver_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the stepper half-step driver
// Shorthand for clocked, reset-qualified concurrent checks.
// ---------------------------------------------------------------------------
`ifndef STEPPER_HALF_STEP_DRIVER_DEFINES_SVH
`define STEPPER_HALF_STEP_DRIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define SHD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define SHD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/shd_pkg.sv]
// ---------------------------------------------------------------------------
// Stepper half-step driver package
// Widths, reset values, drive tables and the types shared by the modules.
// ---------------------------------------------------------------------------
package shd_pkg;

	localparam int BASE_W      = 24;
	localparam int RAMP_W      = 4;
	localparam int CFG_W       = 24;
	localparam int CFG_IDX_W   = 1;
	localparam int PROD_W      = 28;
	localparam int PHASE_W     = 3;
	localparam int STEPS_W     = 32;
	localparam int COIL_W      = 4;
	localparam int TIMER_WIDTH_DEF = 28;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS  = 1'd1;

	localparam logic [BASE_W-1:0] BASE_PERIOD_RST = 24'd6132;
	localparam logic [RAMP_W-1:0] RAMP_STEPS_RST  = 4'd10;

	localparam logic [COIL_W-1:0] SEQ_FWD [8] = '{
		4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
	};
	localparam logic [COIL_W-1:0] SEQ_REV [8] = '{
		4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1
	};

	typedef struct packed {
		logic tick;
		logic service;
		logic run;
		logic forward;
	} item_t;

	typedef struct packed {
		logic [COIL_W-1:0]  coils;
		logic               stepped;
		logic [STEPS_W-1:0] step_total;
		logic               running;
	} result_t;

	typedef struct packed {
		logic accept;
		logic start_div;
		logic finish;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} sts_t;

endpackage

[rtl/core/shd_stream_if.sv]
// ---------------------------------------------------------------------------
// Stream channel interface
// Valid/ready handshake carrying one payload word per transfer.
// ---------------------------------------------------------------------------
interface shd_stream_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

[rtl/core/stepper_half_step_driver.sv]
// ---------------------------------------------------------------------------
// Stepper half-step driver, top level
// Four-coil half-step sequencer with a start ramp and a step timer.
// ---------------------------------------------------------------------------
// Each input word is one tick of the driver and yields exactly one result
// word, registered in the same cycle as the word is accepted, except for a
// service word that advances the start ramp. Its new step period comes from
// a restoring divider that resolves one quotient bit per cycle; the word
// waits in the divide state until the divider is done and in the finish state
// until the output is free, when its result is registered. No input is taken
// meanwhile. The result sits in a single output register; a new word is taken
// only while it is empty or its word is taken in the same cycle, so a
// waiting result holds off the input. The user must write configuration via
// cfg_we, cfg_index and cfg_data only while the driver is idle; not enforced.
`include "stepper_half_step_driver_defines.svh"

module stepper_half_step_driver
	import shd_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	shd_stream_if.sink           ctrl,
	shd_stream_if.source         drive
);

	cmd_t    cmd;
	sts_t    sts;
	result_t result;

	shd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ctrl.valid),
		.in_ready  (ctrl.ready),
		.out_valid (drive.valid),
		.out_ready (drive.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	shd_datapath #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (ctrl.data),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

	assign drive.data = result;

	`SHD_ASSERT_NEXT(a_div_blocks_input, cmd.start_div, !ctrl.ready, "input taken during division")
	`SHD_ASSERT_SAME(a_step_drives_coils, drive.valid && result.stepped, result.coils != '0, "step with coils off")
	`SHD_ASSERT_SAME(a_no_step_when_stopped, drive.valid && !result.running, !result.stepped, "step while stopped")

endmodule

[rtl/core/shd_divider.sv]
// ---------------------------------------------------------------------------
// Ramp period divider
// Restoring divider producing one quotient bit per cycle.
// ---------------------------------------------------------------------------
module shd_divider
	import shd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [RAMP_W-1:0] divisor,
	output logic [PROD_W-1:0] quot,
	output logic              done
);

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] quot_q;
	logic [RAMP_W-1:0] rem_q;
	logic [RAMP_W-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [RAMP_W:0]   trial;
	logic [RAMP_W:0]   diff;
	logic              ge;

	assign trial = {rem_q, quot_q[PROD_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[PROD_W-2:0], ge};
			rem_q  <= ge ? diff[RAMP_W-1:0] : trial[RAMP_W-1:0];
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

[rtl/core/shd_datapath.sv]
// ---------------------------------------------------------------------------
// Stepper driver datapath
// Configuration, motion state, step timer, ramp division and result word.
// ---------------------------------------------------------------------------
module shd_datapath
	import shd_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  item_t                item,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output result_t              result
);

	localparam int SAT_W = (TIMER_WIDTH > PROD_W) ? TIMER_WIDTH : PROD_W;
	localparam logic [SAT_W-1:0] TMAX = SAT_W'((64'd1 << TIMER_WIDTH) - 64'd1);

	logic [BASE_W-1:0]      base_q;
	logic [RAMP_W-1:0]      ramp_q;
	logic [PHASE_W-1:0]     phase_q, phase_n;
	logic                   dir_q, dir_n;
	logic                   run_seen_q, run_seen_n;
	logic                   timer_q, timer_n;
	logic [RAMP_W-1:0]      stage_q, stage_n, stage_e;
	logic [TIMER_WIDTH-1:0] period_q, period_n, period_div;
	logic [TIMER_WIDTH-1:0] count_q, count_n;
	logic [TIMER_WIDTH:0]   cnt_inc;
	logic [STEPS_W-1:0]     steps_q, steps_n;
	logic [COIL_W-1:0]      coil_q, coil_n;
	logic                   stepped;
	logic                   tick_q, tick_v;
	logic                   rising;
	logic                   need_div;
	logic [PROD_W-1:0]      quot;
	logic [SAT_W-1:0]       quot_ext;
	logic [RAMP_W-1:0]      divisor;
	logic                   div_done;
	result_t                out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_PERIOD_RST;
			ramp_q <= RAMP_STEPS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_PERIOD: base_q <= cfg_data[BASE_W-1:0];
				REG_RAMP_STEPS:  ramp_q <= cfg_data[RAMP_W-1:0];
				default: ;
			endcase
		end
	end

	assign rising   = item.service && !run_seen_q && item.run;
	assign stage_e  = rising ? RAMP_W'(1) : stage_q;
	assign need_div = item.service && item.run && (stage_e < ramp_q);
	assign divisor  = (stage_e == '0) ? RAMP_W'(1) : stage_e;

	shd_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_div),
		.dividend (PROD_W'(ramp_q) * PROD_W'(base_q)),
		.divisor  (divisor),
		.quot     (quot),
		.done     (div_done)
	);

	assign quot_ext   = SAT_W'(quot);
	assign period_div = (quot_ext > TMAX) ? TIMER_WIDTH'(TMAX) : TIMER_WIDTH'(quot_ext);

	always_comb begin
		phase_n    = phase_q;
		dir_n      = dir_q;
		run_seen_n = run_seen_q;
		timer_n    = timer_q;
		stage_n    = stage_q;
		period_n   = period_q;
		count_n    = count_q;
		steps_n    = steps_q;
		coil_n     = coil_q;
		stepped    = 1'b0;
		if (cmd.finish) begin
			period_n = period_div;
			count_n  = '0;
			stage_n  = stage_q + 1'b1;
			tick_v   = tick_q;
		end else begin
			if (item.forward != dir_q) begin
				phase_n = ~phase_q;
			end
			dir_n = item.forward;
			if (item.service) begin
				if (rising) begin
					stage_n = RAMP_W'(1);
					timer_n = 1'b1;
				end
				if (run_seen_q && !item.run) begin
					timer_n = 1'b0;
					coil_n  = '0;
				end
				run_seen_n = item.run;
			end
			tick_v = item.tick && !need_div;
		end
		cnt_inc = {1'b0, count_n} + 1'b1;
		if (tick_v && timer_n) begin
			if (cnt_inc >= {1'b0, period_n}) begin
				count_n = '0;
				coil_n  = dir_n ? SEQ_FWD[phase_n] : SEQ_REV[phase_n];
				phase_n = phase_n + 1'b1;
				steps_n = steps_q + 1'b1;
				stepped = 1'b1;
			end else begin
				count_n = cnt_inc[TIMER_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			dir_q      <= 1'b1;
			run_seen_q <= 1'b0;
			timer_q    <= 1'b0;
			stage_q    <= '0;
			period_q   <= TIMER_WIDTH'(BASE_PERIOD_RST);
			count_q    <= '0;
			steps_q    <= '0;
			coil_q     <= '0;
		end else if (cmd.accept || cmd.finish) begin
			phase_q    <= phase_n;
			dir_q      <= dir_n;
			run_seen_q <= run_seen_n;
			timer_q    <= timer_n;
			stage_q    <= stage_n;
			period_q   <= period_n;
			count_q    <= count_n;
			steps_q    <= steps_n;
			coil_q     <= coil_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			tick_q <= item.tick;
		end
		if (cmd.load_out) begin
			out_q.coils      <= coil_n;
			out_q.stepped    <= stepped;
			out_q.step_total <= steps_n;
			out_q.running    <= timer_n;
		end
	end

	assign sts.need_div = need_div;
	assign sts.div_done = div_done;
	assign result       = out_q;

endmodule

[rtl/core/shd_ctrl.sv]
// ---------------------------------------------------------------------------
// Stepper driver controller
// Sequences acceptance, ramp division and delivery of result words.
// ---------------------------------------------------------------------------
module shd_ctrl
	import shd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q, state_n;
	logic       out_valid_q;
	logic       slot_free;
	logic       accept;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;

	assign cmd.accept    = accept;
	assign cmd.start_div = accept && sts.need_div;
	assign cmd.finish    = (state_q == S_FIN) && slot_free;
	assign cmd.load_out  = (accept && !sts.need_div) || cmd.finish;

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && sts.need_div) begin
					state_n = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_n = S_FIN;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
